>>> rtl/rps_pkg.sv
// Shared constants and types for the random permutation shuffler.
package rps_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int VALUE_W = 7;
  localparam int POS_W = 6;
  localparam int WORD_W = 32;
  localparam int LEN_W = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int LEN_RESET = 64;
  localparam int REG_PERM_LENGTH = 0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B
  } rps_state_t;

endpackage

>>> rtl/rps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/rps_mod.sv
// Bit-serial restoring modulo unit: 32-bit word modulo a small count.
module rps_mod (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rps_pkg::WORD_W-1:0]    dividend,
  input  logic [rps_pkg::COUNT_W-1:0]   divisor,
  output logic                          done,
  output logic [rps_pkg::ADDR_W-1:0]    remainder
);
  import rps_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [WORD_W-1:0]   dvd;
  logic [COUNT_W-1:0]  dsr;
  logic [COUNT_W-1:0]  rem;
  logic [COUNT_W-1:0]  rem_next;
  logic [COUNT_W:0]    trial;

  always_comb begin
    trial = {rem, dvd[WORD_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = COUNT_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[WORD_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[ADDR_W-1:0];

endmodule

>>> rtl/random_permutation_shuffler.sv
// Top level of the random permutation shuffler (backward Fisher-Yates).
//
// Each input request carries one 32-bit random word and produces exactly one
// output request: the slot that just became final, its value, and a last flag.
// A shuffle of n entries takes n input requests; the first request after idle
// samples perm_length (0 is taken as 1, values above 64 saturate to 64).
// Slots are emitted from n-1 down to 0, and the request for slot 0 sets last.
// Each request runs through the bit-serial modulo unit and then through the
// reads and writes on the single permutation RAM (RD_A, RD_B, WR_A, WR_B)
// before its output is valid. The next request is accepted in the cycle after
// the output register loads, so no request is taken while one is in progress.
// The output register is loaded only when it is empty or being drained; if
// the receiver stalls, the block holds the finished result and waits.
// perm_length is written over the APB port and is sampled only when a new
// shuffle starts. Reset ends any shuffle, clears all entry valid bits so the
// store reads as identity, and sets perm_length to 64.
module random_permutation_shuffler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rps_pkg::PADDR_W-1:0]   paddr,
  input  logic [rps_pkg::PDATA_W-1:0]   pwdata,
  output logic [rps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rps_pkg::WORD_W-1:0]    random_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rps_pkg::POS_W-1:0]     position,
  output logic [rps_pkg::VALUE_W-1:0]   slot_value,
  output logic                          last
);
  import rps_pkg::*;

  rps_state_t            state;
  rps_state_t            state_next;
  logic [LEN_W-1:0]      perm_length;
  logic [COUNT_W-1:0]    steps_left;
  logic [COUNT_W-1:0]    start_count;
  logic [COUNT_W-1:0]    cur_count;
  logic [MAX_ENTRIES-1:0] written_mask;
  logic [ADDR_W-1:0]     idx;
  logic [ADDR_W-1:0]     top_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [VALUE_W-1:0]    a_val;
  logic [VALUE_W-1:0]    read_val;
  logic                  accept;
  logic                  mod_done;
  logic [ADDR_W-1:0]     mod_rem;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [VALUE_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [VALUE_W-1:0]    ram_rdata;
  logic                  emit;
  logic                  is_last;

  assign pready = 1'b1;
  assign prdata = PDATA_W'(perm_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_length <= LEN_W'(LEN_RESET);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1] == 1'(REG_PERM_LENGTH)) begin
      perm_length <= pwdata[LEN_W-1:0];
    end
  end

  always_comb begin
    if (perm_length == '0) begin
      start_count = COUNT_W'(1);
    end else if (COUNT_W'(perm_length) > COUNT_W'(MAX_ENTRIES)) begin
      start_count = COUNT_W'(MAX_ENTRIES);
    end else begin
      start_count = COUNT_W'(perm_length);
    end
  end

  // A request that arrives while no shuffle runs starts a new one.
  assign cur_count = (steps_left == '0) ? start_count : steps_left;

  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign top_addr = ADDR_W'(steps_left - 1'b1);
  assign is_last = (steps_left == COUNT_W'(1));

  rps_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .dividend  (random_word),
    .divisor   (cur_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  rps_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_perm_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Entries never written since the last clear read as identity.
  assign read_val = written_mask[rd_addr] ? ram_rdata : VALUE_W'(rd_addr) + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_WR_A;
      ST_WR_A: state_next = ST_WR_B;
      ST_WR_B: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = read_val;
    ram_raddr = idx;
    emit      = 1'b0;
    case (state)
      ST_RD_B: ram_raddr = top_addr;
      ST_WR_A: ram_we = 1'b1;
      ST_WR_B: begin
        ram_waddr = top_addr;
        ram_wdata = a_val;
        emit      = !out_valid || out_ready;
        ram_we    = emit;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      steps_left   <= '0;
      written_mask <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        steps_left <= cur_count;
      end
      if (state == ST_WR_A) begin
        written_mask[idx] <= 1'b1;
      end
      if (emit) begin
        if (is_last) begin
          written_mask <= '0;
          steps_left   <= '0;
        end else begin
          written_mask[top_addr] <= 1'b1;
          steps_left             <= steps_left - 1'b1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= ram_raddr;
    if (state == ST_DIV && mod_done) begin
      idx <= mod_rem;
    end
    if (state == ST_RD_B) begin
      a_val <= read_val;
    end
    if (emit) begin
      position   <= POS_W'(top_addr);
      slot_value <= a_val;
      last       <= is_last;
    end
  end

`ifndef SYNTH
  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIV && steps_left != '0)
    else $error("request accepted without starting a step");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    steps_left <= COUNT_W'(MAX_ENTRIES))
    else $error("step count above store depth");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && mod_done) |-> COUNT_W'(mod_rem) < steps_left)
    else $error("swap index outside active range");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (emit && is_last) |=> steps_left == '0 && written_mask == '0)
    else $error("store not returned to identity after last slot");
`endif

endmodule

>>> tb/sv/shuffle_checker.sv
// Checker for the permutation shuffler: tracks length writes, predicts each slot and compares.
module shuffle_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [rps_pkg::PADDR_W-1:0]   paddr,
  input  logic [rps_pkg::PDATA_W-1:0]   pwdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [rps_pkg::WORD_W-1:0]    random_word,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [rps_pkg::POS_W-1:0]     position,
  input  logic [rps_pkg::VALUE_W-1:0]   slot_value,
  input  logic                          last,
  output int                            fail_count,
  output int                            slots_awaited,
  output int                            results_checked,
  output int                            shuffles_seen
);
  import rps_pkg::*;

  localparam int REG_STRIDE = 4;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic               last;
  } slot_result_t;

  logic [VALUE_W-1:0] perm_entries [MAX_ENTRIES];
  bit                 entry_written [MAX_ENTRIES];
  int unsigned        steps_to_go;
  logic [LEN_W-1:0]   length_reg;
  slot_result_t       awaited_slots [$];
  slot_result_t       want;

  initial begin
    fail_count = 0;
    slots_awaited = 0;
    results_checked = 0;
    shuffles_seen = 0;
  end

  function automatic void clear_written();
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      entry_written[k] = 1'b0;
    end
  endfunction

  function automatic logic [VALUE_W-1:0] entry_value(input int unsigned k);
    return entry_written[k] ? perm_entries[k] : VALUE_W'(k + 1);
  endfunction

  // One backward Fisher-Yates step: swap entry (word mod i) with entry i-1.
  function automatic slot_result_t shuffle_step(input logic [WORD_W-1:0] word);
    int unsigned count;
    int unsigned pick;
    logic [VALUE_W-1:0] a_val;
    logic [VALUE_W-1:0] b_val;
    slot_result_t res;
    if (steps_to_go == 0) begin
      count = length_reg;
      if (count == 0) begin
        count = 1;
      end
      if (count > MAX_ENTRIES) begin
        count = MAX_ENTRIES;
      end
      clear_written();
      steps_to_go = count;
    end
    count = steps_to_go;
    pick = word % count;
    a_val = entry_value(pick);
    b_val = entry_value(count - 1);
    perm_entries[pick] = b_val;
    entry_written[pick] = 1'b1;
    perm_entries[count - 1] = a_val;
    entry_written[count - 1] = 1'b1;
    res.position = POS_W'(count - 1);
    res.value = a_val;
    res.last = (count == 1);
    if (res.last) begin
      clear_written();
      steps_to_go = 0;
    end else begin
      steps_to_go = count - 1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        perm_entries[k] = VALUE_W'(k + 1);
      end
      clear_written();
      steps_to_go = 0;
      length_reg = LEN_W'(LEN_RESET);
      awaited_slots.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == PADDR_W'(REG_PERM_LENGTH * REG_STRIDE)) begin
        length_reg = pwdata[LEN_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (awaited_slots.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result position %0d value %0d last %0d",
                   $time, position, slot_value, last);
        end else begin
          want = awaited_slots.pop_front();
          results_checked++;
          if (want.last) begin
            shuffles_seen++;
          end
          if (position !== want.position) begin
            fail_count++;
            $display("%0t: position mismatch, expected %0d actual %0d",
                     $time, want.position, position);
          end
          if (slot_value !== want.value) begin
            fail_count++;
            $display("%0t: slot_value mismatch at position %0d, expected %0d actual %0d",
                     $time, want.position, want.value, slot_value);
          end
          if (last !== want.last) begin
            fail_count++;
            $display("%0t: last mismatch at position %0d, expected %0d actual %0d",
                     $time, want.position, want.last, last);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_slots.push_back(shuffle_step(random_word));
      end
    end
    slots_awaited = awaited_slots.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the shuffler testbench: clock, reset, request and register stimulus, verdict.
module testbench;
  import rps_pkg::*;

  localparam int REG_STRIDE = 4;
  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(REG_STRIDE);
  localparam logic [PADDR_W-1:0] LENGTH_ADDR = PADDR_W'(REG_PERM_LENGTH * REG_STRIDE);
  localparam int WORD_TARGET = 850;
  localparam int DRAIN_CYCLES = 60;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [WORD_W-1:0]   random_word;
  logic                out_valid;
  logic                out_ready;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  slot_value;
  logic                last;

  int fail_count;
  int slots_awaited;
  int results_checked;
  int shuffles_seen;

  int send_calm;
  int recv_calm;
  int words_sent;
  int reg_writes;
  logic [LEN_W-1:0] next_len;

  random_permutation_shuffler dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .random_word (random_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .position    (position),
    .slot_value  (slot_value),
    .last        (last)
  );

  shuffle_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .random_word     (random_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .position        (position),
    .slot_value      (slot_value),
    .last            (last),
    .fail_count      (fail_count),
    .slots_awaited   (slots_awaited),
    .results_checked (results_checked),
    .shuffles_seen   (shuffles_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still awaited.", slots_awaited);
    $display("*** FAILED ***");
    $finish;
  end

  // Random idle length, with occasional runs of back-to-back requests.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic int shuffle_size(input logic [LEN_W-1:0] len);
    if (len == 0) begin
      return 1;
    end
    if (len > MAX_ENTRIES) begin
      return MAX_ENTRIES;
    end
    return len;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(0, 255));
      3: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PDATA_W-1:0] length_word();
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 9))
      0: len = '0;
      1: len = 1;
      2: len = 2;
      3: len = LEN_W'(MAX_ENTRIES);
      4: len = LEN_W'($urandom_range(MAX_ENTRIES + 1, 127));
      default: len = LEN_W'($urandom_range(1, MAX_ENTRIES));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      return ($urandom() & ~PDATA_W'(127)) | PDATA_W'(len);
    end
    return PDATA_W'(len);
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] word);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    random_word <= word;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    words_sent++;
  endtask

  task automatic feed_words(input int count);
    repeat (count) send_word(pick_word());
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(negedge clk);
    while (slots_awaited != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic set_length(input logic [PDATA_W-1:0] data);
    write_reg(LENGTH_ADDR, data);
    next_len = data[LEN_W-1:0];
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    recv_calm = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    int n;
    int split;
    int reps;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    random_word = '0;
    send_calm = 0;
    words_sent = 0;
    reg_writes = 0;
    next_len = LEN_W'(LEN_RESET);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The first shuffle runs at the length left by reset.
    send_word('1);
    send_word('0);
    feed_words(shuffle_size(next_len) - 2);
    quiesce();

    set_length('0);
    send_word('1);
    quiesce();
    set_length(PDATA_W'(1));
    write_reg(UNMAPPED_ADDR, PDATA_W'(127));
    send_word('0);
    quiesce();
    set_length(PDATA_W'(2));
    send_word('1);
    send_word(WORD_W'(1));
    quiesce();
    set_length(32'hFFFF_FF83);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    send_word(32'h5555_5555);
    quiesce();

    // A length written mid-shuffle must wait for the next shuffle.
    set_length(PDATA_W'(5));
    send_word(32'hAAAA_AAAA);
    send_word(32'h1234_5678);
    quiesce();
    set_length(PDATA_W'(2));
    send_word('0);
    send_word('1);
    send_word(32'hDEAD_BEEF);
    send_word(32'h5555_5555);
    send_word(32'hFFFF_FFFE);
    quiesce();

    while (words_sent < WORD_TARGET) begin
      set_length(length_word());
      n = shuffle_size(next_len);
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        if (n > 1 && $urandom_range(0, 5) == 0) begin
          split = $urandom_range(1, n - 1);
          feed_words(split);
          quiesce();
          set_length(length_word());
          feed_words(n - split);
        end else begin
          feed_words(n);
        end
        n = shuffle_size(next_len);
      end
      quiesce();
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d random words with %0d register writes, lengths zero to saturating.",
             words_sent, reg_writes);
    $display("Compared %0d slot results over %0d completed shuffles.",
             results_checked, shuffles_seen);
    if (fail_count == 0 && slots_awaited == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
